### src/rsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsr_pkg;

	typedef enum logic {
		OP_LOAD     = 1'b0,
		OP_REGULATE = 1'b1
	} op_t;

	typedef enum logic {
		REG_CURRENT_MARGIN    = 1'b0,
		REG_TEMPERATURE_LIMIT = 1'b1
	} reg_index_t;

	localparam logic [1:0] ACTION_HOLD     = 2'd0;
	localparam logic [1:0] ACTION_INCREASE = 2'd1;
	localparam logic [1:0] ACTION_DECREASE = 2'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	localparam int CFG_W = 16;
	localparam int ACC_W = 40;

	// Q16.16 coefficients of the target polynomial; rounding half folded into C
	localparam logic [14:0] COEF_A     = 15'd21002;
	localparam logic [24:0] COEF_B     = 25'd19511757;
	localparam logic [26:0] COEF_C_RND = 27'd67161833;

	localparam logic [22:0] RPM_MAX = 23'h7FFFFF;

	// x / 10 == (x * DIV10_M) >> DIV10_SH for any x below 2**26
	localparam logic [23:0] DIV10_M  = 24'd13421773;
	localparam int          DIV10_SH = 27;

	typedef struct packed {
		op_t                op;
		logic        [11:0] velocity;
		logic        [22:0] motor_rpm;
		logic signed [15:0] motor_current;
		logic signed [15:0] temperature;
		logic signed [15:0] table_value;
	} in_item_t;

	typedef struct packed {
		logic [22:0] new_rpm;
		logic [22:0] target_rpm;
		logic [1:0]  action;
		logic [1:0]  status;
		logic [10:0] table_position;
	} out_item_t;

endpackage

`default_nettype wire

### src/rpm_step_regulator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// in        in_valid/in_ready    in_data   (rsr_pkg::in_item_t)
// out       out_valid/out_ready  out_data  (rsr_pkg::out_item_t)
// cfg       cfg_we               cfg_index, cfg_data
//
// An item passes through stages 1 to 4 and then the output register, and only one item
// is in the stages at a time: no new item is taken until stage 4 has passed its result on.
// The stages follow the chain velocity^2 -> A*v^2 -> target -> target/10.
// The table read is a synchronous memory read issued in the accept cycle.
// arst_n resets the fill count, table position, configuration registers and valid bits;
// the table and the stage data are not cleared. A stalled output holds the item in stage 4.

module rpm_step_regulator #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire rsr_pkg::in_item_t      in_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output rsr_pkg::out_item_t          out_data,
	input  wire logic                   cfg_we,
	input  wire rsr_pkg::reg_index_t    cfg_index,
	input  wire logic [rsr_pkg::CFG_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int ACC_W_L = rsr_pkg::ACC_W;

	// configuration
	logic        [14:0] margin_q;
	logic signed [15:0] temp_limit_q;

	// control state
	logic [CNT_W-1:0] entries_q;
	logic [CNT_W-1:0] position_q;
	logic             v_s1, v_s2, v_s3, v_s4;
	logic             out_valid_q;
	rsr_pkg::out_item_t out_q;

	// table memory
	logic [15:0] mem_q [TABLE_DEPTH];
	logic [15:0] rd_q;

	// stage 1
	rsr_pkg::op_t       op_s1;
	logic        [22:0] rpm_s1;
	logic signed [15:0] cur_s1;
	logic signed [15:0] temp_s1;
	logic        [23:0] vsq_s1;
	logic        [36:0] bv_s1;
	logic        [1:0]  status_s1;
	logic               skip_s1;

	// stage 2
	rsr_pkg::op_t       op_s2;
	logic        [22:0] rpm_s2;
	logic        [ACC_W_L-1:0] avsq_s2;
	logic        [ACC_W_L-1:0] bvc_s2;
	logic        [1:0]  status_s2;
	logic               skip_s2;
	logic               cur_lt_s2, cur_gt_s2, temp_lt_s2, temp_gt_s2;

	// stage 3
	logic        [22:0] rpm_s3;
	logic        [22:0] target_s3;
	logic        [1:0]  status_s3;
	logic               skip_s3;
	logic               cur_lt_s3, cur_gt_s3, temp_lt_s3, temp_gt_s3;

	// stage 4
	logic        [22:0] rpm_s4;
	logic        [22:0] target_s4;
	logic        [47:0] prod_s4;
	logic        [1:0]  status_s4;
	logic               skip_s4;
	logic               up_s4, down_s4;

	logic               accept;
	logic               is_load;
	logic               table_full;
	logic               exhausted;
	logic               out_adv;
	logic               in_band;
	logic signed [17:0] cur_x, opt_x, marg_x;
	logic        [ACC_W_L-1:0] acc_sum;
	logic        [23:0] tgt_raw;
	logic        [22:0] tgt_sat;
	logic        [23:0] tgt_rnd;
	logic        [20:0] step;
	logic        [23:0] inc_sum;
	logic        [22:0] inc_rpm, dec_rpm;
	rsr_pkg::out_item_t out_d;

	assign in_ready   = !(v_s1 || v_s2 || v_s3 || v_s4);
	assign accept     = in_valid && in_ready;
	assign is_load    = (in_data.op == rsr_pkg::OP_LOAD);
	assign table_full = (entries_q >= CNT_W'(TABLE_DEPTH));
	assign exhausted  = (position_q >= entries_q);
	assign out_adv    = v_s4 && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q     <= 15'd0;
			temp_limit_q <= 16'sh7FFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rsr_pkg::REG_CURRENT_MARGIN:    margin_q     <= cfg_data[14:0];
				rsr_pkg::REG_TEMPERATURE_LIMIT: temp_limit_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// table memory: write on load while not full, read at the current position
	always_ff @(posedge clk) begin
		if (accept && is_load && !table_full)
			mem_q[entries_q[IDX_W-1:0]] <= in_data.table_value;
		if (accept)
			rd_q <= mem_q[position_q[IDX_W-1:0]];
	end

	// band compare against the entry read during stage 1
	always_comb begin
		cur_x   = 18'(cur_s1);
		opt_x   = 18'($signed(rd_q));
		marg_x  = $signed({3'b000, margin_q});
		in_band = (cur_x >= opt_x - marg_x) && (cur_x <= opt_x + marg_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q   <= '0;
			position_q  <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && is_load && !table_full)
				entries_q <= entries_q + CNT_W'(1);
			if (v_s1 && !skip_s1 && in_band)
				position_q <= position_q + CNT_W'(1);
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3)
				v_s4 <= 1'b1;
			else if (out_adv)
				v_s4 <= 1'b0;
			if (out_adv)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// stage 1: capture, velocity products
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= in_data.op;
			rpm_s1  <= in_data.motor_rpm;
			cur_s1  <= in_data.motor_current;
			temp_s1 <= in_data.temperature;
			vsq_s1  <= 24'(in_data.velocity) * 24'(in_data.velocity);
			bv_s1   <= 37'(rsr_pkg::COEF_B) * 37'(in_data.velocity);
			if (is_load) begin
				status_s1 <= table_full ? rsr_pkg::STATUS_FULL : rsr_pkg::STATUS_OK;
				skip_s1   <= 1'b1;
			end else begin
				status_s1 <= exhausted ? rsr_pkg::STATUS_EXHAUSTED : rsr_pkg::STATUS_OK;
				skip_s1   <= exhausted;
			end
		end
	end

	// stage 2: quadratic term, compares
	always_ff @(posedge clk) begin
		if (v_s1) begin
			op_s2      <= op_s1;
			rpm_s2     <= rpm_s1;
			avsq_s2    <= ACC_W_L'(rsr_pkg::COEF_A) * ACC_W_L'(vsq_s1);
			bvc_s2     <= ACC_W_L'(bv_s1) + ACC_W_L'(rsr_pkg::COEF_C_RND);
			status_s2  <= status_s1;
			skip_s2    <= skip_s1;
			cur_lt_s2  <= cur_s1 < $signed(rd_q);
			cur_gt_s2  <= cur_s1 > $signed(rd_q);
			temp_lt_s2 <= temp_s1 < temp_limit_q;
			temp_gt_s2 <= temp_s1 > temp_limit_q;
		end
	end

	always_comb begin
		acc_sum = avsq_s2 + bvc_s2;
		tgt_raw = acc_sum[39:16];
		tgt_sat = (tgt_raw > 24'(rsr_pkg::RPM_MAX)) ? rsr_pkg::RPM_MAX : tgt_raw[22:0];
	end

	// stage 3: target rpm
	always_ff @(posedge clk) begin
		if (v_s2) begin
			rpm_s3     <= rpm_s2;
			target_s3  <= tgt_sat;
			status_s3  <= status_s2;
			skip_s3    <= skip_s2 || (op_s2 == rsr_pkg::OP_LOAD);
			cur_lt_s3  <= cur_lt_s2;
			cur_gt_s3  <= cur_gt_s2;
			temp_lt_s3 <= temp_lt_s2;
			temp_gt_s3 <= temp_gt_s2;
		end
	end

	assign tgt_rnd = 24'(target_s3) + 24'd5;

	// stage 4: step by reciprocal multiply, direction decision
	always_ff @(posedge clk) begin
		if (v_s3) begin
			rpm_s4    <= rpm_s3;
			target_s4 <= target_s3;
			prod_s4   <= 48'(tgt_rnd) * 48'(rsr_pkg::DIV10_M);
			status_s4 <= status_s3;
			skip_s4   <= skip_s3;
			up_s4     <= cur_lt_s3 && temp_lt_s3 && (rpm_s3 < target_s3);
			down_s4   <= cur_gt_s3 || temp_gt_s3 || (rpm_s3 > target_s3);
		end
	end

	always_comb begin
		step    = prod_s4[47:rsr_pkg::DIV10_SH];
		inc_sum = 24'(rpm_s4) + 24'(step);
		inc_rpm = (inc_sum > 24'(rsr_pkg::RPM_MAX)) ? rsr_pkg::RPM_MAX : inc_sum[22:0];
		dec_rpm = (rpm_s4 >= 23'(step)) ? rpm_s4 - 23'(step) : 23'd0;

		out_d.new_rpm        = rpm_s4;
		out_d.target_rpm     = target_s4;
		out_d.action         = rsr_pkg::ACTION_HOLD;
		out_d.status         = status_s4;
		out_d.table_position = 11'(position_q);
		if (!skip_s4) begin
			if (up_s4) begin
				out_d.new_rpm = inc_rpm;
				out_d.action  = rsr_pkg::ACTION_INCREASE;
			end else if (down_s4) begin
				out_d.new_rpm = dec_rpm;
				out_d.action  = rsr_pkg::ACTION_DECREASE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv)
			out_q <= out_d;
	end

	// only one transaction is ever in flight through the stages
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({v_s1, v_s2, v_s3, v_s4}) <= 1)
		else $error("more than one item in flight");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entries_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		position_q <= entries_q)
		else $error("table position past loaded entries");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s4))
		else $error("result appeared without a stage 4 item");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(position_q != $past(position_q)) |-> $past(v_s1))
		else $error("table position moved outside stage 1");

endmodule

`default_nettype wire
